FILE: rtl/blst_pkg.sv
package blst_pkg;

  // field widths
  localparam int OP_W  = 3;
  localparam int VAL_W = 8;
  localparam int ST_W  = 3;
  localparam int AMT_W = 7;

  // default sizes
  localparam int CAPACITY_DEF    = 32;
  localparam int CMD_QUEUE_DEPTH = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
  localparam logic [OP_W-1:0] OP_READ_FWD = 3'd2;
  localparam logic [OP_W-1:0] OP_READ_BWD = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

  // result status codes
  localparam logic [ST_W-1:0] ST_DONE      = 3'd0;
  localparam logic [ST_W-1:0] ST_ELEMENT   = 3'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

  // command passed from front to back
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
  } cmd_t;

endpackage

FILE: rtl/byte_list_store.sv
// Ordered list of bytes with push-front, remove-all-matching, forward and
// backward read, and clear. Commands enter through a two-entry queue, so
// the input side keeps taking transactions while the execution side works
// or while a result waits to be popped. Push, clear and any command on an
// empty list load the result register as they leave the queue. Remove walks
// the list through the entry memory, one entry per cycle. A read emits one
// element per cycle from the registered read port, as fast as the result
// side pops. Operation codes 5 to 7 are taken and dropped without a result.
// The entry memory holds CAPACITY bytes, has no reset and needs no clearing
// after reset.
module byte_list_store #(
  parameter int CAPACITY = blst_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [blst_pkg::OP_W-1:0]  in_operation,
  input  logic [blst_pkg::VAL_W-1:0] in_value,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [blst_pkg::ST_W-1:0]  out_status,
  output logic [blst_pkg::VAL_W-1:0] out_element,
  output logic [blst_pkg::AMT_W-1:0] out_amount,
  output logic                       out_last
);
  import blst_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_nonempty;
  cmd_t q_head;

  // input classification
  blst_front u_front (
    .in_push      (in_push),
    .in_full      (in_full),
    .in_operation (in_operation),
    .in_value     (in_value),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  // command queue between front and back
  blst_cmd_queue #(
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head_cmd (q_head)
  );

  // list execution and result register
  blst_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (q_nonempty),
    .cmd         (q_head),
    .cmd_pop     (q_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_status  (out_status),
    .out_element (out_element),
    .out_amount  (out_amount),
    .out_last    (out_last)
  );

endmodule

FILE: rtl/blst_front.sv
module blst_front (
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [blst_pkg::OP_W-1:0]  in_operation,
  input  logic [blst_pkg::VAL_W-1:0] in_value,
  input  logic                      q_full,
  output logic                      q_push,
  output blst_pkg::cmd_t            q_cmd
);
  import blst_pkg::*;

  logic op_legal;

  // classify the operation; undefined codes are taken and dropped
  always_comb begin
    unique case (in_operation)
      OP_PUSH, OP_REMOVE, OP_READ_FWD, OP_READ_BWD, OP_CLEAR: op_legal = 1'b1;
      default: op_legal = 1'b0;
    endcase
  end

  // hand legal commands to the queue
  assign in_full      = q_full;
  assign q_push       = in_push && !q_full && op_legal;
  assign q_cmd.op     = in_operation;
  assign q_cmd.value  = in_value;

endmodule

FILE: rtl/blst_cmd_queue.sv
module blst_cmd_queue #(
  parameter int DEPTH = blst_pkg::CMD_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  blst_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output blst_pkg::cmd_t head_cmd
);
  import blst_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r,  cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == DEPTH_C);
  assign nonempty = (cnt_r != '0);
  assign head_cmd = slot_r[rptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  // pointer and fill count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // command storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/blst_back.sv
module blst_back #(
  parameter int CAPACITY = blst_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  input  blst_pkg::cmd_t             cmd,
  output logic                       cmd_pop,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [blst_pkg::ST_W-1:0]  out_status,
  output logic [blst_pkg::VAL_W-1:0] out_element,
  output logic [blst_pkg::AMT_W-1:0] out_amount,
  output logic                       out_last
);
  import blst_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
  localparam logic [AW:0]   CAP_W    = (AW + 1)'(CAPACITY);
  localparam logic [AW-1:0] TOP_ADDR = AW'(CAPACITY - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RM   = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;

  // control state
  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] head_r,  head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pend_r,  pend_nxt;
  logic          res_valid_r, res_valid_nxt;

  // per-command working registers
  logic [CW-1:0]    idx_r,  idx_nxt;
  logic [CW-1:0]    kept_r, kept_nxt;
  logic [AW-1:0]    cur_r,  cur_nxt;
  logic             bwd_r,  bwd_nxt;
  logic [VAL_W-1:0] val_r,  val_nxt;

  // result register
  logic [ST_W-1:0]  res_status_r;
  logic [VAL_W-1:0] res_element_r;
  logic [AMT_W-1:0] res_amount_r;
  logic             res_last_r;

  // entry memory
  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata_r;
  logic [AW-1:0]    raddr;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;

  // result load
  logic             ld;
  logic [ST_W-1:0]  ld_status;
  logic [VAL_W-1:0] ld_element;
  logic [CW-1:0]    ld_amount;

  logic          slot_free;
  logic          rd_last;
  logic [AW-1:0] head_m1;

  // physical address of a list position in the circular store
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CAP_W) begin
      sum = sum - CAP_W;
    end
    return sum[AW-1:0];
  endfunction

  // list position of the c-th element in read order
  function automatic logic [AW-1:0] read_pos(input logic bwd, input logic [CW-1:0] cnt,
                                             input logic [AW-1:0] c);
    logic [CW-1:0] cw_c;
    logic [CW-1:0] pos;
    cw_c = CW'(c);
    pos  = bwd ? (cnt - 1'b1 - cw_c) : cw_c;
    return pos[AW-1:0];
  endfunction

  assign slot_free = !res_valid_r || out_pop;
  assign rd_last   = (CW'(cur_r) == count_r - 1'b1);
  assign head_m1   = (head_r == '0) ? TOP_ADDR : head_r - 1'b1;

  // command sequencer
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    pend_nxt   = pend_r;
    idx_nxt    = idx_r;
    kept_nxt   = kept_r;
    cur_nxt    = cur_r;
    bwd_nxt    = bwd_r;
    val_nxt    = val_r;
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = head_m1;
    mem_wdata  = cmd.value;
    raddr      = head_r;
    ld         = 1'b0;
    ld_status  = ST_DONE;
    ld_element = '0;
    ld_amount  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_pop = 1'b1;
          val_nxt = cmd.value;
          unique case (cmd.op)
            OP_PUSH: begin
              ld = 1'b1;
              if (count_r == CAP_C) begin
                ld_status = ST_FULL;
                ld_amount = count_r;
              end else begin
                mem_we    = 1'b1;
                head_nxt  = head_m1;
                count_nxt = count_r + 1'b1;
                ld_status = ST_DONE;
                ld_amount = count_r + 1'b1;
              end
            end
            OP_REMOVE: begin
              if (count_r == '0) begin
                ld        = 1'b1;
                ld_status = ST_NOT_FOUND;
              end else begin
                // first read goes out now
                idx_nxt   = CW'(1);
                pend_nxt  = 1'b1;
                kept_nxt  = '0;
                state_nxt = S_RM;
              end
            end
            OP_READ_FWD, OP_READ_BWD: begin
              if (count_r == '0) begin
                ld        = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                bwd_nxt   = (cmd.op == OP_READ_BWD);
                cur_nxt   = '0;
                raddr     = phys(head_r, read_pos(cmd.op == OP_READ_BWD, count_r, '0));
                state_nxt = S_RD;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
              ld        = 1'b1;
              ld_status = ST_DONE;
            end
            default: begin
            end
          endcase
        end
      end
      S_RM: begin
        // issue the next read
        if (idx_r < count_r) begin
          raddr    = phys(head_r, idx_r[AW-1:0]);
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        // compact the entry read last cycle
        if (pend_r) begin
          if (rdata_r != val_r) begin
            mem_we    = 1'b1;
            mem_waddr = phys(head_r, kept_r[AW-1:0]);
            mem_wdata = rdata_r;
            kept_nxt  = kept_r + 1'b1;
          end
        end else begin
          count_nxt = kept_r;
          ld        = 1'b1;
          state_nxt = S_IDLE;
          if (kept_r == count_r) begin
            ld_status = ST_NOT_FOUND;
            ld_amount = count_r;
          end else begin
            ld_status = ST_DONE;
            ld_amount = count_r - kept_r;
          end
        end
      end
      S_RD: begin
        // one element per transaction; the read address runs one ahead
        raddr = phys(head_r, read_pos(bwd_r, count_r, cur_r));
        if (slot_free) begin
          ld         = 1'b1;
          ld_status  = ST_ELEMENT;
          ld_element = rdata_r;
          ld_amount  = count_r;
          if (rd_last) begin
            state_nxt = S_IDLE;
          end else begin
            cur_nxt = cur_r + 1'b1;
            raddr   = phys(head_r, read_pos(bwd_r, count_r, cur_r + 1'b1));
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    res_valid_nxt = ld || (res_valid_r && !out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    kept_r <= kept_nxt;
    cur_r  <= cur_nxt;
    bwd_r  <= bwd_nxt;
    val_r  <= val_nxt;
    if (ld) begin
      res_status_r  <= ld_status;
      res_element_r <= ld_element;
      res_amount_r  <= AMT_W'(ld_amount);
      res_last_r    <= (state_r != S_RD) || rd_last;
    end
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign out_empty   = !res_valid_r;
  assign out_status  = res_status_r;
  assign out_element = res_element_r;
  assign out_amount  = res_amount_r;
  assign out_last    = res_last_r;

  // list length never exceeds the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count above capacity");

  // compaction never produces a result before it finishes
  a_rm_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RM) |-> !res_valid_r)
    else $error("result pending during remove");

  // compaction write pointer trails the read pointer
  a_rm_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RM) |-> (kept_r <= idx_r && idx_r <= count_r))
    else $error("remove pointers out of order");

  // read walk stays inside the list
  a_rd_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (CW'(cur_r) < count_r))
    else $error("read cursor beyond list");

endmodule
